@@ design/tbc_pkg.sv @@
// shared types, constants and arctangent table of the tilt balance controller
`default_nettype none
package tbc_pkg;

	localparam int ATAN_TAB_LEN = 24;
	localparam int CORDIC_XW = 33;
	localparam int CORDIC_ZW = 28;
	localparam logic signed [CORDIC_ZW-1:0] HALF_PI_Q24 = 28'sd26353589;

	typedef enum logic [2:0] {
		CFG_COEF_A        = 3'd0,
		CFG_COEF_B        = 3'd1,
		CFG_GYRO_SCALE    = 3'd2,
		CFG_GAIN_P        = 3'd3,
		CFG_GAIN_D        = 3'd4,
		CFG_ANGLE_OFFSET  = 3'd5,
		CFG_FRICTION_COMP = 3'd6,
		CFG_COMMAND_LIMIT = 3'd7
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CORDIC = 4'b0010,
		ST_MATH   = 4'b0100,
		ST_WAIT   = 4'b1000
	} ctrl_state_t;

	function automatic logic signed [CORDIC_ZW-1:0] atan_q24(input logic [4:0] i);
		logic signed [CORDIC_ZW-1:0] r;
		unique case (i)
			5'd0:  r = 28'sd13176795;
			5'd1:  r = 28'sd7778716;
			5'd2:  r = 28'sd4110060;
			5'd3:  r = 28'sd2086331;
			5'd4:  r = 28'sd1047214;
			5'd5:  r = 28'sd524117;
			5'd6:  r = 28'sd262123;
			5'd7:  r = 28'sd131069;
			5'd8:  r = 28'sd65536;
			5'd9:  r = 28'sd32768;
			5'd10: r = 28'sd16384;
			5'd11: r = 28'sd8192;
			5'd12: r = 28'sd4096;
			5'd13: r = 28'sd2048;
			5'd14: r = 28'sd1024;
			5'd15: r = 28'sd512;
			5'd16: r = 28'sd256;
			5'd17: r = 28'sd128;
			5'd18: r = 28'sd64;
			5'd19: r = 28'sd32;
			5'd20: r = 28'sd16;
			5'd21: r = 28'sd8;
			5'd22: r = 28'sd4;
			5'd23: r = 28'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ design/tbc_cordic.sv @@
// iterative vectoring cordic for atan2, one micro-rotation per cycle
`default_nettype none
module tbc_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [15:0] y_in,
	input  wire logic signed [15:0] x_in,
	output logic                    done,
	output logic signed [15:0]      angle
);
	import tbc_pkg::*;

	localparam int STEPS = (CORDIC_STEPS > ATAN_TAB_LEN) ? ATAN_TAB_LEN : CORDIC_STEPS;
	localparam logic [4:0] LAST = 5'(STEPS - 1);

	logic signed [CORDIC_XW-1:0] x_q, y_q, xs, ys, xi, yi;
	logic signed [CORDIC_ZW-1:0] z_q, zr;
	logic [4:0] i_q;
	logic busy_q, done_q;

	assign xi = CORDIC_XW'(x_in) <<< 14;
	assign yi = CORDIC_XW'(y_in) <<< 14;
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				i_q <= i_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			priority if (x_in >= 0) begin
				x_q <= xi;
				y_q <= yi;
				z_q <= '0;
			end else if (y_in >= 0) begin
				x_q <= yi;
				y_q <= -xi;
				z_q <= HALF_PI_Q24;
			end else begin
				x_q <= -yi;
				y_q <= xi;
				z_q <= -HALF_PI_Q24;
			end
		end else if (busy_q) begin
			if (y_q < 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_q24(i_q);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_q24(i_q);
			end
		end
	end

	assign zr    = (z_q + CORDIC_ZW'(2048)) >>> 12;
	assign angle = zr[15:0];
	assign done  = done_q;

endmodule
`default_nettype wire

@@ design/tilt_balance_controller_top.sv @@
// tilt balance controller top: config registers, sequencer, shared multiplier, outputs
// An enabled word passes through the cordic, the math steps and the wait state before the next accept;
// a disabled word skips the cordic and starts the math at the tilt step. The result is valid in the same
// cycle that the block is ready again. The arctangent runs one cordic rotation per cycle, then a single
// shared 34x17 multiplier does the filter, pd and pwm products one per cycle.
// A finished word sits in an output register, so the next word is taken meanwhile; a word
// that finishes while the previous result is still waiting holds until that one is taken.
// Config writes are taken at any time but are meant only while the block is idle.
`default_nettype none
module tilt_balance_controller_top #(
	parameter int PWM_FULL_SCALE = 4095,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] gyro_z,
	input  wire logic signed [15:0] angle_setpoint,
	input  wire logic               enable,
	input  wire logic signed [13:0] turn,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [13:0]      pwm_right,
	output logic signed [13:0]      pwm_left,
	output logic signed [15:0]      tilt_estimate,
	output logic                    saturated,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);
	import tbc_pkg::*;

	localparam int EXT = (PWM_FULL_SCALE + 1) / 8;
	localparam int LO0 = -EXT;
	localparam int HI0 = PWM_FULL_SCALE + EXT;
	localparam int LO = (LO0 < -8192) ? -8192 : LO0;
	localparam int HI = (HI0 > 8191) ? 8191 : HI0;
	localparam logic signed [31:0] PWM_LO = 32'(LO);
	localparam logic signed [31:0] PWM_HI = 32'(HI);
	localparam int MID0 = (2048 * PWM_FULL_SCALE) / 4096;
	localparam int MID = (MID0 > HI) ? HI : MID0;
	localparam logic signed [13:0] PWM_MID = 14'(MID);
	localparam logic signed [16:0] PWM_FS = 17'(PWM_FULL_SCALE);
	localparam logic [3:0] STEP_TILT = 4'd6;

	// config registers
	logic [15:0] coef_a_q, coef_b_q, gyro_scale_q, gain_p_q, gain_d_q;
	logic signed [15:0] angle_offset_q;
	logic [11:0] friction_comp_q, command_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q        <= 16'd910;
			coef_b_q        <= 16'd31858;
			gyro_scale_q    <= 16'd3124;
			gain_p_q        <= 16'd13292;
			gain_d_q        <= 16'd1508;
			angle_offset_q  <= -16'sd134;
			friction_comp_q <= 12'd641;
			command_limit_q <= 12'd1843;
		end else if (cfg_valid) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_COEF_A:        coef_a_q        <= cfg_data;
				CFG_COEF_B:        coef_b_q        <= cfg_data;
				CFG_GYRO_SCALE:    gyro_scale_q    <= cfg_data;
				CFG_GAIN_P:        gain_p_q        <= cfg_data;
				CFG_GAIN_D:        gain_d_q        <= cfg_data;
				CFG_ANGLE_OFFSET:  angle_offset_q  <= cfg_data;
				CFG_FRICTION_COMP: friction_comp_q <= cfg_data[11:0];
				CFG_COMMAND_LIMIT: command_limit_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// captured word
	logic signed [15:0] gz_q, sp_q;
	logic signed [13:0] turn_q;
	logic en_q;

	ctrl_state_t state_q;
	logic [3:0] step_q;
	logic cordic_start, cordic_done;
	logic signed [15:0] cordic_angle, tg_q;

	// shared multiplier
	logic signed [33:0] op1;
	logic signed [16:0] op2;
	logic signed [50:0] p_q, prod;
	logic signed [51:0] acc_q, fsum;
	logic signed [31:0] af_q, gf_q, fsat;
	logic signed [32:0] ssum;
	logic signed [17:0] tsh, err;
	logic signed [15:0] tilt_q, held_q;
	logic signed [23:0] cmd, tr, trc;
	logic signed [12:0] lim;
	logic sat_c;
	logic signed [15:0] tr_q;
	logic signed [31:0] base_q, tt, rsum, lsum, rcl, lcl;
	logic signed [13:0] right_q, left_q;
	logic signed [15:0] out_tilt_q;
	logic sat_q, out_sat_q, out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign cordic_start = in_valid && in_ready && enable;

	tbc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.y_in   (accel_y),
		.x_in   (accel_x),
		.done   (cordic_done),
		.angle  (cordic_angle)
	);

	always_comb begin
		op1 = '0;
		op2 = '0;
		unique case (step_q)
			4'd0:  begin op1 = 34'(tg_q);        op2 = 17'(coef_a_q); end
			4'd1:  begin op1 = 34'(af_q);        op2 = 17'(coef_b_q); end
			4'd2:  begin op1 = 34'(gz_q);        op2 = 17'(gyro_scale_q); end
			4'd3:  begin op1 = p_q[33:0];        op2 = 17'(coef_a_q); end
			4'd4:  begin op1 = 34'(gf_q);        op2 = 17'(coef_b_q); end
			4'd7:  begin op1 = 34'(err);         op2 = 17'(gain_p_q); end
			4'd8:  begin op1 = 34'(gz_q);        op2 = 17'(gain_d_q); end
			4'd10: begin op1 = 34'(tr_q) + 34'sd2048; op2 = PWM_FS; end
			4'd11: begin op1 = 34'(turn_q);      op2 = PWM_FS; end
			default: ;
		endcase
	end

	assign prod = 51'(op1) * 51'(op2);

	assign fsum = acc_q + 52'(p_q >>> 15);
	always_comb begin
		if (fsum > 52'sd2147483647) fsat = 32'sh7fffffff;
		else if (fsum < -52'sd2147483648) fsat = 32'sh80000000;
		else fsat = fsum[31:0];
	end

	assign ssum = 33'(af_q) + 33'(gf_q);
	assign tsh  = 18'(ssum >>> 15);
	assign err  = 18'(sp_q) + 18'(angle_offset_q) - 18'(tilt_q);
	assign lim  = 13'(command_limit_q);

	always_comb begin
		cmd = 24'((acc_q - 52'(p_q)) >>> 12);
		if (cmd < 0) tr = cmd - 24'(friction_comp_q);
		else if (cmd > 0) tr = cmd + 24'(friction_comp_q);
		else tr = 24'(held_q);
		sat_c = 1'b0;
		trc = tr;
		if (tr > 24'(lim)) begin
			trc = 24'(lim);
			sat_c = 1'b1;
		end else if (tr < -24'(lim)) begin
			trc = -24'(lim);
			sat_c = 1'b1;
		end
	end

	assign tt   = 32'(p_q >>> 12);
	assign rsum = base_q + tt;
	assign lsum = base_q - tt;
	assign rcl  = (rsum < PWM_LO) ? PWM_LO : ((rsum > PWM_HI) ? PWM_HI : rsum);
	assign lcl  = (lsum < PWM_LO) ? PWM_LO : ((lsum > PWM_HI) ? PWM_HI : lsum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			af_q        <= '0;
			gf_q        <= '0;
			held_q      <= '0;
		end else begin
			if (state_q == ST_WAIT && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (enable) begin
							state_q <= ST_CORDIC;
						end else begin
							state_q <= ST_MATH;
							step_q  <= STEP_TILT;
						end
					end
				end
				ST_CORDIC: begin
					if (cordic_done) begin
						state_q <= ST_MATH;
						step_q  <= '0;
					end
				end
				ST_MATH: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd2) af_q <= fsat;
					if (step_q == 4'd5) gf_q <= fsat;
					if (step_q == 4'd9) held_q <= trc[15:0];
					if ((step_q == STEP_TILT && !en_q) || step_q == 4'd11) state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			gz_q   <= gyro_z;
			sp_q   <= angle_setpoint;
			en_q   <= enable;
			turn_q <= turn;
		end
		if (cordic_done) tg_q <= -cordic_angle;
		if (state_q == ST_MATH) begin
			p_q <= prod;
			unique case (step_q)
				4'd1:  acc_q <= 52'(p_q);
				4'd4:  acc_q <= 52'(p_q >>> 12);
				4'd6: begin
					if (tsh > 18'sd32767) tilt_q <= 16'sh7fff;
					else if (tsh < -18'sd32768) tilt_q <= 16'sh8000;
					else tilt_q <= tsh[15:0];
					if (!en_q) sat_q <= 1'b0;
				end
				4'd8:  acc_q <= 52'(p_q);
				4'd9: begin
					tr_q  <= trc[15:0];
					sat_q <= sat_c;
				end
				4'd11: base_q <= 32'(p_q >>> 12);
				default: ;
			endcase
		end
		if (state_q == ST_WAIT && out_free) begin
			right_q    <= en_q ? rcl[13:0] : PWM_MID;
			left_q     <= en_q ? lcl[13:0] : PWM_MID;
			out_tilt_q <= tilt_q;
			out_sat_q  <= sat_q;
		end
	end

	// p_q holds turn*fs when ST_WAIT is reached from the last multiply
	assign out_valid     = out_valid_q;
	assign pwm_right     = right_q;
	assign pwm_left      = left_q;
	assign tilt_estimate = out_tilt_q;
	assign saturated     = out_sat_q;

	a_cordic_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		cordic_done |-> state_q == ST_CORDIC)
		else $error("cordic finished outside its state");

	a_disabled_mid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAIT && out_free && !en_q |=>
		pwm_right == PWM_MID && pwm_left == PWM_MID && !saturated)
		else $error("disabled word not at mid-scale");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && en_q && sat_q |->
		tr_q == 16'(lim) || tr_q == -16'(lim))
		else $error("saturated command off the limit");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MATH |-> !in_ready)
		else $error("ready while computing");

endmodule
`default_nettype wire
